@@ src/phea_pkg.sv @@
// ----------------------------------------------------------------------------
// phea_pkg
// Shared types, widths and helpers for the position histogram and energy
// accumulator.
// ----------------------------------------------------------------------------
package phea_pkg;

  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int POS_W      = 32;
  localparam int SCALE_W    = 24;
  localparam int ENERGY_W   = 24;
  localparam int BIN_W      = 4;
  localparam int COUNT_W    = 32;
  localparam int SUM_W      = 64;
  localparam int SQ_W       = 2 * ENERGY_W;
  localparam int DIFF_W     = POS_W + 1;
  localparam int PROD_W     = DIFF_W + SCALE_W + 1;
  localparam int FRAC_W     = 32;
  // wide enough for any axis bin index up to 127
  localparam int IDX_W      = 7;

  localparam logic [POS_W-1:0]   ORIGIN_RST = 32'hFFFE_8000;
  localparam logic [SCALE_W-1:0] SCALE_RST  = 24'd349525;

  typedef enum logic {
    CMD_RECORD = 1'b0,
    CMD_READ   = 1'b1
  } cmd_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_X_ORIGIN = 3'd0,
    REG_Y_ORIGIN = 3'd1,
    REG_Z_ORIGIN = 3'd2,
    REG_X_SCALE  = 3'd3,
    REG_Y_SCALE  = 3'd4,
    REG_Z_SCALE  = 3'd5
  } reg_idx_e;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    sat_inc = (c == '1) ? c : c + COUNT_W'(1);
  endfunction

endpackage

@@ src/phea_sample_if.sv @@
// ----------------------------------------------------------------------------
// phea_sample_if
// Sample and read command channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface phea_sample_if
  import phea_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic                       command;
  logic signed [ENERGY_W-1:0] local_energy;
  logic                       accepted;
  logic signed [POS_W-1:0]    pos_x;
  logic signed [POS_W-1:0]    pos_y;
  logic signed [POS_W-1:0]    pos_z;
  logic [BIN_W-1:0]           read_x;
  logic [BIN_W-1:0]           read_y;
  logic [BIN_W-1:0]           read_z;

  modport source (
    output valid, command, local_energy, accepted, pos_x, pos_y, pos_z,
           read_x, read_y, read_z,
    input  ready
  );

  modport sink (
    input  valid, command, local_energy, accepted, pos_x, pos_y, pos_z,
           read_x, read_y, read_z,
    output ready
  );
endinterface

@@ src/phea_result_if.sv @@
// ----------------------------------------------------------------------------
// phea_result_if
// Result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface phea_result_if
  import phea_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [ENERGY_W-1:0] energy_echo;
  logic                       in_range;
  logic [BIN_W-1:0]           bin_x;
  logic [BIN_W-1:0]           bin_y;
  logic [BIN_W-1:0]           bin_z;
  logic [COUNT_W-1:0]         bin_count;
  logic signed [SUM_W-1:0]    energy_sum;
  logic [SUM_W-1:0]           energy_sq_sum;
  logic [COUNT_W-1:0]         step_count;
  logic [COUNT_W-1:0]         accepted_count;

  modport source (
    output valid, energy_echo, in_range, bin_x, bin_y, bin_z, bin_count,
           energy_sum, energy_sq_sum, step_count, accepted_count,
    input  ready
  );

  modport sink (
    input  valid, energy_echo, in_range, bin_x, bin_y, bin_z, bin_count,
           energy_sum, energy_sq_sum, step_count, accepted_count,
    output ready
  );
endinterface

@@ src/position_histogram_energy_accumulator_unit.sv @@
// ----------------------------------------------------------------------------
// position_histogram_energy_accumulator_unit
// Bins Q16.16 positions into a 3D histogram held in one synchronous memory
// and keeps saturating energy sums and step counters.
// Registers: difference, multiply, update and output stages, in that order.
// Throughput: one beat per cycle unless the result channel stalls; the
// histogram read-modify-write forwards the count written in the same cycle as a read of the same bin.
// Reset: a clearing pass writes zero to all BINS_X*BINS_Y*BINS_Z bins
// (4096 bins by default) while the sample channel is held not ready.
// ----------------------------------------------------------------------------
module position_histogram_energy_accumulator_unit
  import phea_pkg::*;
#(
  parameter int BINS_X = 16,
  parameter int BINS_Y = 16,
  parameter int BINS_Z = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [REG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  phea_sample_if.sink           sample_i,
  phea_result_if.source         result_o
);

  localparam int CELLS = BINS_X * BINS_Y * BINS_Z;
  localparam int AW    = $clog2(CELLS);
  localparam int HI_W  = PROD_W - 1 - FRAC_W;
  localparam logic [AW-1:0] CLR_LAST = AW'(CELLS - 1);

  // configuration
  logic signed [POS_W-1:0] x_org_q, y_org_q, z_org_q;
  logic [SCALE_W-1:0]      x_scl_q, y_scl_q, z_scl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_org_q <= ORIGIN_RST;
      y_org_q <= ORIGIN_RST;
      z_org_q <= ORIGIN_RST;
      x_scl_q <= SCALE_RST;
      y_scl_q <= SCALE_RST;
      z_scl_q <= SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_X_ORIGIN: x_org_q <= cfg_wdata_i[POS_W-1:0];
        REG_Y_ORIGIN: y_org_q <= cfg_wdata_i[POS_W-1:0];
        REG_Z_ORIGIN: z_org_q <= cfg_wdata_i[POS_W-1:0];
        REG_X_SCALE:  x_scl_q <= cfg_wdata_i[SCALE_W-1:0];
        REG_Y_SCALE:  y_scl_q <= cfg_wdata_i[SCALE_W-1:0];
        REG_Z_SCALE:  z_scl_q <= cfg_wdata_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing pass
  logic          clr_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == CLR_LAST) begin
        clr_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  // pipeline control
  logic dif_v_q, mul_v_q, upd_v_q, out_v_q;
  logic in_acc, mv_mul, mv_upd, load_out;

  assign load_out       = upd_v_q && (!out_v_q || result_o.ready);
  assign mv_upd         = mul_v_q && (!upd_v_q || load_out);
  assign mv_mul         = dif_v_q && (!mul_v_q || mv_upd);
  assign sample_i.ready = !clr_q && (!dif_v_q || mv_mul);
  assign in_acc         = sample_i.valid && sample_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dif_v_q <= 1'b0;
      mul_v_q <= 1'b0;
      upd_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_acc) begin
        dif_v_q <= 1'b1;
      end else if (mv_mul) begin
        dif_v_q <= 1'b0;
      end
      if (mv_mul) begin
        mul_v_q <= 1'b1;
      end else if (mv_upd) begin
        mul_v_q <= 1'b0;
      end
      if (mv_upd) begin
        upd_v_q <= 1'b1;
      end else if (load_out) begin
        upd_v_q <= 1'b0;
      end
      if (load_out) begin
        out_v_q <= 1'b1;
      end else if (result_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // difference stage
  logic                       dif_cmd_q, dif_acc_q;
  logic signed [ENERGY_W-1:0] dif_e_q;
  logic signed [DIFF_W-1:0]   dif_x_q, dif_y_q, dif_z_q;
  logic [BIN_W-1:0]           dif_rx_q, dif_ry_q, dif_rz_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dif_cmd_q <= sample_i.command;
      dif_acc_q <= sample_i.accepted;
      dif_e_q   <= sample_i.local_energy;
      dif_x_q   <= {sample_i.pos_x[POS_W-1], sample_i.pos_x} - {x_org_q[POS_W-1], x_org_q};
      dif_y_q   <= {sample_i.pos_y[POS_W-1], sample_i.pos_y} - {y_org_q[POS_W-1], y_org_q};
      dif_z_q   <= {sample_i.pos_z[POS_W-1], sample_i.pos_z} - {z_org_q[POS_W-1], z_org_q};
      dif_rx_q  <= sample_i.read_x;
      dif_ry_q  <= sample_i.read_y;
      dif_rz_q  <= sample_i.read_z;
    end
  end

  // multiply stage
  logic                       mul_cmd_q, mul_acc_q;
  logic signed [ENERGY_W-1:0] mul_e_q;
  logic signed [SQ_W-1:0]     mul_sq_q;
  logic signed [PROD_W-1:0]   mul_px_q, mul_py_q, mul_pz_q;
  logic [BIN_W-1:0]           mul_rx_q, mul_ry_q, mul_rz_q;
  logic signed [SQ_W-1:0]     sq_d;
  logic signed [PROD_W-1:0]   px_d, py_d, pz_d;

  assign sq_d = dif_e_q * dif_e_q;
  assign px_d = dif_x_q * $signed({1'b0, x_scl_q});
  assign py_d = dif_y_q * $signed({1'b0, y_scl_q});
  assign pz_d = dif_z_q * $signed({1'b0, z_scl_q});

  always_ff @(posedge clk_i) begin
    if (mv_mul) begin
      mul_cmd_q <= dif_cmd_q;
      mul_acc_q <= dif_acc_q;
      mul_e_q   <= dif_e_q;
      mul_sq_q  <= sq_d;
      mul_px_q  <= px_d;
      mul_py_q  <= py_d;
      mul_pz_q  <= pz_d;
      mul_rx_q  <= dif_rx_q;
      mul_ry_q  <= dif_ry_q;
      mul_rz_q  <= dif_rz_q;
    end
  end

  // index stage
  logic [IDX_W-1:0] ix, iy, iz;
  logic             x_ok, y_ok, z_ok, inr_d;
  logic [BIN_W-1:0] bx_d, by_d, bz_d;
  logic [AW-1:0]    addr_d;

  always_comb begin
    if (mul_cmd_q == CMD_READ) begin
      ix   = IDX_W'(mul_rx_q);
      iy   = IDX_W'(mul_ry_q);
      iz   = IDX_W'(mul_rz_q);
      x_ok = ix < IDX_W'(BINS_X);
      y_ok = iy < IDX_W'(BINS_Y);
      z_ok = iz < IDX_W'(BINS_Z);
    end else begin
      ix   = mul_px_q[FRAC_W +: IDX_W];
      iy   = mul_py_q[FRAC_W +: IDX_W];
      iz   = mul_pz_q[FRAC_W +: IDX_W];
      x_ok = !mul_px_q[PROD_W-1] && (mul_px_q[PROD_W-2:FRAC_W] < HI_W'(BINS_X));
      y_ok = !mul_py_q[PROD_W-1] && (mul_py_q[PROD_W-2:FRAC_W] < HI_W'(BINS_Y));
      z_ok = !mul_pz_q[PROD_W-1] && (mul_pz_q[PROD_W-2:FRAC_W] < HI_W'(BINS_Z));
    end
    inr_d = x_ok && y_ok && z_ok;
    if (mul_cmd_q == CMD_READ) begin
      bx_d = mul_rx_q;
      by_d = mul_ry_q;
      bz_d = mul_rz_q;
    end else if (inr_d) begin
      bx_d = ix[BIN_W-1:0];
      by_d = iy[BIN_W-1:0];
      bz_d = iz[BIN_W-1:0];
    end else begin
      bx_d = '0;
      by_d = '0;
      bz_d = '0;
    end
    addr_d = AW'((32'(ix) * 32'(BINS_Y) + 32'(iy)) * 32'(BINS_Z) + 32'(iz));
  end

  // update stage
  logic                       upd_cmd_q, upd_acc_q, upd_inr_q;
  logic signed [ENERGY_W-1:0] upd_e_q;
  logic signed [SQ_W-1:0]     upd_sq_q;
  logic [BIN_W-1:0]           upd_bx_q, upd_by_q, upd_bz_q;
  logic [AW-1:0]              upd_addr_q;
  logic                       fwd_q;
  logic [COUNT_W-1:0]         fwd_data_q, rdata_q;
  logic [COUNT_W-1:0]         cnt_cur, cnt_new;
  logic                       upd_wr, fwd_d;

  assign cnt_cur = fwd_q ? fwd_data_q : rdata_q;
  assign cnt_new = sat_inc(cnt_cur);
  assign upd_wr  = (upd_cmd_q == CMD_RECORD) && upd_inr_q;
  assign fwd_d   = load_out && upd_wr && (upd_addr_q == addr_d);

  always_ff @(posedge clk_i) begin
    if (mv_upd) begin
      upd_cmd_q  <= mul_cmd_q;
      upd_acc_q  <= mul_acc_q;
      upd_inr_q  <= inr_d;
      upd_e_q    <= mul_e_q;
      upd_sq_q   <= mul_sq_q;
      upd_bx_q   <= bx_d;
      upd_by_q   <= by_d;
      upd_bz_q   <= bz_d;
      upd_addr_q <= addr_d;
      fwd_q      <= fwd_d;
      fwd_data_q <= cnt_new;
    end
  end

  // histogram memory
  logic [COUNT_W-1:0] hist_mem [CELLS];
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [COUNT_W-1:0] mem_wdata;

  assign mem_we    = clr_q || (load_out && upd_wr);
  assign mem_waddr = clr_q ? clr_addr_q : upd_addr_q;
  assign mem_wdata = clr_q ? '0 : cnt_new;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    if (mv_upd) begin
      rdata_q <= hist_mem[addr_d];
    end
  end

  // totals
  logic signed [SUM_W-1:0] esum_q, esum_d, esum_add, e_ext;
  logic [SUM_W-1:0]        esq_q, esq_d;
  logic [SUM_W:0]          esq_add;
  logic [COUNT_W-1:0]      step_q, accn_q;
  logic                    esum_ovf;

  always_comb begin
    e_ext    = SUM_W'(upd_e_q);
    esum_add = esum_q + e_ext;
    esum_ovf = (esum_q[SUM_W-1] == e_ext[SUM_W-1]) && (esum_add[SUM_W-1] != esum_q[SUM_W-1]);
    if (esum_ovf) begin
      esum_d = e_ext[SUM_W-1] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      esum_d = esum_add;
    end
    esq_add = {1'b0, esq_q} + (SUM_W+1)'($unsigned(upd_sq_q));
    esq_d   = esq_add[SUM_W] ? '1 : esq_add[SUM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esum_q <= '0;
      esq_q  <= '0;
      step_q <= '0;
      accn_q <= '0;
    end else if (load_out && (upd_cmd_q == CMD_RECORD)) begin
      esum_q <= esum_d;
      esq_q  <= esq_d;
      step_q <= sat_inc(step_q);
      if (upd_acc_q) begin
        accn_q <= sat_inc(accn_q);
      end
    end
  end

  // output register
  logic signed [ENERGY_W-1:0] out_echo_q;
  logic                       out_inr_q;
  logic [BIN_W-1:0]           out_bx_q, out_by_q, out_bz_q;
  logic [COUNT_W-1:0]         out_cnt_q;

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_echo_q <= (upd_cmd_q == CMD_RECORD) ? upd_e_q : '0;
      out_inr_q  <= upd_inr_q;
      out_bx_q   <= upd_bx_q;
      out_by_q   <= upd_by_q;
      out_bz_q   <= upd_bz_q;
      if (!upd_inr_q) begin
        out_cnt_q <= '0;
      end else if (upd_cmd_q == CMD_RECORD) begin
        out_cnt_q <= cnt_new;
      end else begin
        out_cnt_q <= cnt_cur;
      end
    end
  end

  assign result_o.valid          = out_v_q;
  assign result_o.energy_echo    = out_echo_q;
  assign result_o.in_range       = out_inr_q;
  assign result_o.bin_x          = out_bx_q;
  assign result_o.bin_y          = out_by_q;
  assign result_o.bin_z          = out_bz_q;
  assign result_o.bin_count      = out_cnt_q;
  assign result_o.energy_sum     = esum_q;
  assign result_o.energy_sq_sum  = esq_q;
  assign result_o.step_count     = step_q;
  assign result_o.accepted_count = accn_q;

  // checks
  a_acc_le_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accn_q <= step_q)
    else $error("accepted count exceeds step count");

  a_steps_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> step_q >= $past(step_q))
    else $error("step count decreased");

  a_clr_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !(dif_v_q || mul_v_q || upd_v_q || out_v_q))
    else $error("pipeline busy during clearing pass");

  a_out_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_inr_q) |-> (out_cnt_q == '0))
    else $error("nonzero count for out-of-range beat");

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives sample and read beats into the histogram and energy accumulator and
// checks every result beat, field by field, against an in-order prediction.
// A short directed table covers the reset state, the field extremes and the
// edges of each axis range. Random phases follow, each under its own set of
// origins and scales. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import phea_pkg::*;

  localparam int BINS         = 16;
  localparam int LATENCY      = 3;
  localparam int PHASES       = 6;
  localparam int PHASE_BEATS  = 150;
  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_PRINTS   = 40;

  localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam reg_idx_e ORIGIN_REG [3] = '{REG_X_ORIGIN, REG_Y_ORIGIN, REG_Z_ORIGIN};
  localparam reg_idx_e SCALE_REG  [3] = '{REG_X_SCALE, REG_Y_SCALE, REG_Z_SCALE};

  localparam logic signed [ENERGY_W-1:0] E_MAX = 24'sh7F_FFFF;
  localparam logic signed [ENERGY_W-1:0] E_MIN = 24'sh80_0000;
  localparam logic signed [POS_W-1:0]    P_ORG = -32'sd98304;
  localparam logic signed [POS_W-1:0]    P_TOP = 32'sd98304;

  typedef struct packed {
    cmd_e                       command;
    logic signed [ENERGY_W-1:0] energy;
    logic                       accepted;
    logic signed [POS_W-1:0]    pos_x;
    logic signed [POS_W-1:0]    pos_y;
    logic signed [POS_W-1:0]    pos_z;
    logic [BIN_W-1:0]           read_x;
    logic [BIN_W-1:0]           read_y;
    logic [BIN_W-1:0]           read_z;
  } sample_t;

  typedef struct packed {
    logic signed [ENERGY_W-1:0] energy_echo;
    logic                       in_range;
    logic [BIN_W-1:0]           bin_x;
    logic [BIN_W-1:0]           bin_y;
    logic [BIN_W-1:0]           bin_z;
    logic [COUNT_W-1:0]         bin_count;
    logic signed [SUM_W-1:0]    energy_sum;
    logic [SUM_W-1:0]           energy_sq_sum;
    logic [COUNT_W-1:0]         step_count;
    logic [COUNT_W-1:0]         accepted_count;
  } tally_t;

  typedef struct packed {
    sample_t sample;
    logic    known;
    tally_t  want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [REG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  phea_sample_if sample_if ();
  phea_result_if result_if ();

  position_histogram_energy_accumulator_unit u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .sample_i    (sample_if.sink),
    .result_o    (result_if.source)
  );

  // predicted block state
  logic [COUNT_W-1:0]      hist_counts [BINS*BINS*BINS];
  logic signed [SUM_W-1:0] energy_total;
  logic [SUM_W-1:0]        energy_sq_total;
  logic [COUNT_W-1:0]      steps;
  logic [COUNT_W-1:0]      accepted_steps;
  logic signed [POS_W-1:0] axis_origin [3];
  logic [SCALE_W-1:0]      axis_scale  [3];

  tally_t   tally_q [$];
  dir_row_t dir_rows [$];
  sample_t  last_sample;
  logic [BIN_W-1:0] last_hit [3];
  int errors        = 0;
  int cycles        = 0;
  int hold_requests = 0;
  int holds_served  = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic logic axis_bin(input logic signed [POS_W-1:0] pos,
                                    input logic signed [POS_W-1:0] origin,
                                    input logic [SCALE_W-1:0] scale,
                                    output logic [BIN_W-1:0] idx);
    logic signed [63:0] d;
    logic signed [63:0] p;
    d = {{32{pos[31]}}, pos} - {{32{origin[31]}}, origin};
    p = d * $signed({40'd0, scale});
    idx = '0;
    if (p < 0 || p[63:32] >= BINS) return 1'b0;
    idx = p[32 +: BIN_W];
    return 1'b1;
  endfunction

  function automatic tally_t histogram_update(input sample_t s);
    tally_t r;
    logic signed [64:0] esum;
    logic signed [47:0] e48;
    logic [64:0] qsum;
    logic [BIN_W-1:0] bx, by, bz;
    logic ok;
    r = '0;
    if (s.command == CMD_RECORD) begin
      esum = {energy_total[63], energy_total} + {{41{s.energy[23]}}, s.energy};
      if (esum[64] != esum[63])
        energy_total = esum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      else
        energy_total = esum[63:0];
      e48 = {{24{s.energy[23]}}, s.energy};
      qsum = {1'b0, energy_sq_total} + {17'd0, e48 * e48};
      energy_sq_total = qsum[64] ? '1 : qsum[63:0];
      steps = bump(steps);
      if (s.accepted) accepted_steps = bump(accepted_steps);
      ok = axis_bin(s.pos_x, axis_origin[0], axis_scale[0], bx);
      ok = axis_bin(s.pos_y, axis_origin[1], axis_scale[1], by) && ok;
      ok = axis_bin(s.pos_z, axis_origin[2], axis_scale[2], bz) && ok;
      if (ok) begin
        hist_counts[{bx, by, bz}] = bump(hist_counts[{bx, by, bz}]);
        r.in_range  = 1'b1;
        r.bin_x     = bx;
        r.bin_y     = by;
        r.bin_z     = bz;
        r.bin_count = hist_counts[{bx, by, bz}];
        last_hit    = '{bx, by, bz};
      end
      r.energy_echo = s.energy;
    end else begin
      r.bin_x = s.read_x;
      r.bin_y = s.read_y;
      r.bin_z = s.read_z;
      if (s.read_x < BINS && s.read_y < BINS && s.read_z < BINS) begin
        r.in_range  = 1'b1;
        r.bin_count = hist_counts[{s.read_x, s.read_y, s.read_z}];
      end
    end
    r.energy_sum     = energy_total;
    r.energy_sq_sum  = energy_sq_total;
    r.step_count     = steps;
    r.accepted_count = accepted_steps;
    return r;
  endfunction

  function automatic sample_t rec(input logic signed [ENERGY_W-1:0] e, input logic acc,
                                  input logic signed [POS_W-1:0] x, y, z);
    return '{CMD_RECORD, e, acc, x, y, z, 4'd0, 4'd0, 4'd0};
  endfunction

  function automatic sample_t rd(input logic [BIN_W-1:0] x, y, z);
    return '{CMD_READ, 24'sd0, 1'b0, 32'sd0, 32'sd0, 32'sd0, x, y, z};
  endfunction

  function automatic tally_t known(input logic signed [ENERGY_W-1:0] echo,
                                   input logic inr,
                                   input logic [COUNT_W-1:0] count,
                                   input logic signed [SUM_W-1:0] sum,
                                   input logic [SUM_W-1:0] sq,
                                   input logic [COUNT_W-1:0] n, acc);
    return '{echo, inr, 4'd0, 4'd0, 4'd0, count, sum, sq, n, acc};
  endfunction

  function automatic logic signed [POS_W-1:0] axis_position(input int a);
    logic [63:0] span;
    logic [31:0] offset;
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return $urandom();
    if (r < 20) return axis_origin[a] + $signed($urandom_range(0, 4)) - 2;
    span = (axis_scale[a] == 0) ? 64'd1 << 20 : (64'd1 << 36) / axis_scale[a];
    if (span > 64'd1 << 31) span = 64'd1 << 31;
    if (r < 30) offset = span[31:0] + $urandom_range(0, 4) - 2;
    else offset = $urandom_range(0, span[31:0] + span[31:0] / 8);
    return axis_origin[a] + $signed(offset);
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int r;
    r = $urandom_range(0, 99);
    s.command  = (r < 20) ? CMD_READ : CMD_RECORD;
    s.accepted = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       s.energy = E_MAX;
      1:       s.energy = E_MIN;
      default: s.energy = ENERGY_W'($urandom());
    endcase
    if (r >= 20 && r < 35) begin
      s.pos_x = last_sample.pos_x;
      s.pos_y = last_sample.pos_y;
      s.pos_z = last_sample.pos_z;
    end else begin
      s.pos_x = axis_position(0);
      s.pos_y = axis_position(1);
      s.pos_z = axis_position(2);
    end
    if ($urandom_range(0, 1)) begin
      s.read_x = last_hit[0];
      s.read_y = last_hit[1];
      s.read_z = last_hit[2];
    end else begin
      s.read_x = BIN_W'($urandom());
      s.read_y = BIN_W'($urandom());
      s.read_z = BIN_W'($urandom());
    end
    last_sample = s;
    return s;
  endfunction

  function automatic int idle_gap(input int beat);
    int r;
    if (beat % 64 < 20) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (errors < MAX_PRINTS)
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic offer_sample(input sample_t s, input int gap, input logic is_known,
                              input tally_t want);
    tally_t pred;
    if (gap > 0) begin
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_if.valid        <= 1'b1;
    sample_if.command      <= s.command;
    sample_if.local_energy <= s.energy;
    sample_if.accepted     <= s.accepted;
    sample_if.pos_x        <= s.pos_x;
    sample_if.pos_y        <= s.pos_y;
    sample_if.pos_z        <= s.pos_z;
    sample_if.read_x       <= s.read_x;
    sample_if.read_y       <= s.read_y;
    sample_if.read_z       <= s.read_z;
    do @(posedge clk); while (sample_if.ready !== 1'b1);
    pred = histogram_update(s);
    tally_q.push_back(is_known ? want : pred);
  endtask

  task automatic drain();
    sample_if.valid <= 1'b0;
    while (tally_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_X_ORIGIN: axis_origin[0] = data;
      REG_Y_ORIGIN: axis_origin[1] = data;
      REG_Z_ORIGIN: axis_origin[2] = data;
      REG_X_SCALE:  axis_scale[0]  = data[SCALE_W-1:0];
      REG_Y_SCALE:  axis_scale[1]  = data[SCALE_W-1:0];
      REG_Z_SCALE:  axis_scale[2]  = data[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  // result side: check, then pick next ready
  initial begin
    int hold_left;
    int stall_left;
    int mode_left;
    logic calm;
    tally_t w;
    hold_left  = 0;
    stall_left = 0;
    mode_left  = 0;
    calm       = 1'b0;
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
        if (tally_q.size() == 0) begin
          report_mismatch("beat with nothing expected", 64'd0, 64'd0);
        end else begin
          w = tally_q.pop_front();
          if (result_if.energy_echo !== w.energy_echo)
            report_mismatch("energy_echo", 64'(result_if.energy_echo), 64'(w.energy_echo));
          if (result_if.in_range !== w.in_range)
            report_mismatch("in_range", 64'(result_if.in_range), 64'(w.in_range));
          if (result_if.bin_x !== w.bin_x)
            report_mismatch("bin_x", 64'(result_if.bin_x), 64'(w.bin_x));
          if (result_if.bin_y !== w.bin_y)
            report_mismatch("bin_y", 64'(result_if.bin_y), 64'(w.bin_y));
          if (result_if.bin_z !== w.bin_z)
            report_mismatch("bin_z", 64'(result_if.bin_z), 64'(w.bin_z));
          if (result_if.bin_count !== w.bin_count)
            report_mismatch("bin_count", 64'(result_if.bin_count), 64'(w.bin_count));
          if (result_if.energy_sum !== w.energy_sum)
            report_mismatch("energy_sum", result_if.energy_sum, w.energy_sum);
          if (result_if.energy_sq_sum !== w.energy_sq_sum)
            report_mismatch("energy_sq_sum", result_if.energy_sq_sum, w.energy_sq_sum);
          if (result_if.step_count !== w.step_count)
            report_mismatch("step_count", 64'(result_if.step_count), 64'(w.step_count));
          if (result_if.accepted_count !== w.accepted_count)
            report_mismatch("accepted_count", 64'(result_if.accepted_count),
                            64'(w.accepted_count));
        end
      end
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = 400;
      end
      if (mode_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(0, 2);
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [CFG_DATA_W-1:0] org;
    logic [SCALE_W-1:0] scl;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    sample_if.valid        = 1'b0;
    sample_if.command      = CMD_RECORD;
    sample_if.local_energy = '0;
    sample_if.accepted     = 1'b0;
    sample_if.pos_x        = '0;
    sample_if.pos_y        = '0;
    sample_if.pos_z        = '0;
    sample_if.read_x       = '0;
    sample_if.read_y       = '0;
    sample_if.read_z       = '0;

    foreach (hist_counts[i]) hist_counts[i] = '0;
    energy_total    = '0;
    energy_sq_total = '0;
    steps           = '0;
    accepted_steps  = '0;
    axis_origin     = '{ORIGIN_RST, ORIGIN_RST, ORIGIN_RST};
    axis_scale      = '{SCALE_RST, SCALE_RST, SCALE_RST};
    last_hit        = '{4'd0, 4'd0, 4'd0};
    last_sample     = rd(4'd0, 4'd0, 4'd0);

    dir_rows.push_back('{rd(4'd0, 4'd0, 4'd0), 1'b1,
                         known(24'sd0, 1'b1, 32'd0, 64'sd0, 64'd0, 32'd0, 32'd0)});
    dir_rows.push_back('{rec(E_MAX, 1'b1, P_ORG, P_ORG, P_ORG), 1'b1,
                         known(E_MAX, 1'b1, 32'd1, 64'sd8388607, 64'd70368727400449,
                               32'd1, 32'd1)});
    dir_rows.push_back('{rec(E_MIN, 1'b0, P_ORG - 1, P_ORG, P_ORG), 1'b1,
                         known(E_MIN, 1'b0, 32'd0, -64'sd1, 64'd140737471578113,
                               32'd2, 32'd1)});
    dir_rows.push_back('{rec(24'sd0, 1'b1, P_ORG, P_ORG, P_ORG), 1'b0, '0});
    dir_rows.push_back('{rec(24'sh12_3456, 1'b1, P_ORG, P_ORG, P_ORG), 1'b0, '0});
    dir_rows.push_back('{rd(4'd0, 4'd0, 4'd0), 1'b0, '0});
    dir_rows.push_back('{rec(24'sd1, 1'b0, P_TOP, P_TOP, P_TOP), 1'b0, '0});
    dir_rows.push_back('{rec(-24'sd1, 1'b1, P_TOP + 1, 32'sd0, 32'sd0), 1'b0, '0});
    dir_rows.push_back('{rec(24'sd5, 1'b0, 32'sd0, P_TOP + 1, 32'sd0), 1'b0, '0});
    dir_rows.push_back('{rec(24'sd5, 1'b1, 32'sd0, 32'sd0, P_TOP + 1), 1'b0, '0});
    dir_rows.push_back('{rec(24'sh40_0000, 1'b0, P_ORG, P_ORG - 1, P_ORG), 1'b0, '0});
    dir_rows.push_back('{rec(-24'sh40_0000, 1'b1, 32'sd0, 32'sd0, P_ORG - 1), 1'b0, '0});
    dir_rows.push_back('{rec(E_MAX, 1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF),
                         1'b0, '0});
    dir_rows.push_back('{rec(E_MIN, 1'b0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000),
                         1'b0, '0});
    dir_rows.push_back('{rec(24'sh00_1000, 1'b1, 32'sd0, 32'sd0, 32'sd0), 1'b0, '0});
    dir_rows.push_back('{rd(4'd7, 4'd7, 4'd7), 1'b0, '0});
    dir_rows.push_back('{rd(4'd15, 4'd15, 4'd15), 1'b0, '0});
    dir_rows.push_back('{rd(4'd15, 4'd0, 4'd7), 1'b0, '0});
    dir_rows.push_back('{rec(24'sh00_0800, 1'b0, 32'sd0, 32'sd0, 32'sd0), 1'b0, '0});
    dir_rows.push_back('{rd(4'd7, 4'd7, 4'd7), 1'b0, '0});
    dir_rows.push_back('{rec(24'sh00_0800, 1'b1, P_TOP, 32'sd0, P_ORG), 1'b0, '0});
    dir_rows.push_back('{sample_t'{CMD_READ, E_MAX, 1'b1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                   32'sh7FFF_FFFF, 4'd15, 4'd0, 4'd7}, 1'b0, '0});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      offer_sample(dir_rows[i].sample, (i > 5 && i < 12) ? 0 : idle_gap(i + 30),
                   dir_rows[i].known, dir_rows[i].want);
    drain();

    for (int ph = 1; ph <= PHASES; ph++) begin
      for (int a = 0; a < 3; a++) begin
        case (ph)
          1: begin
            org = 32'h8000_0000;
            scl = 24'hFF_FFFF;
          end
          2: begin
            org = 32'h7FFF_FFFF;
            scl = 24'd0;
          end
          3: begin
            org = ORIGIN_RST;
            scl = SCALE_RST;
          end
          default: begin
            org = $urandom();
            scl = SCALE_W'($urandom_range(1 << 10, 1 << 22));
          end
        endcase
        write_reg(ORIGIN_REG[a], org);
        write_reg(SCALE_REG[a], {8'($urandom()), scl});
      end
      write_reg(REG_SPARE_LO, $urandom());
      write_reg(REG_SPARE_HI, $urandom());
      cfg_we <= 1'b0;
      @(posedge clk);

      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (ph == 3 && i == 20) hold_requests++;
        offer_sample(random_sample(), (ph == 3 && i >= 20 && i < 60) ? 0 : idle_gap(i),
                     1'b0, '0);
      end
      drain();
    end

    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
src/phea_pkg.sv
src/phea_sample_if.sv
src/phea_result_if.sv
src/position_histogram_energy_accumulator_unit.sv
test/testbench.sv
